>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file vsm_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, masked while reset is high
`define VSM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Property checked on every rising clock edge, reset included
`define VSM_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> hdl/vsm_pkg.sv
// ----------------------------------------------------------------------------
// vsm_pkg
// Widths, constants and the fractional exponential table of the softmax.
// ----------------------------------------------------------------------------
`default_nettype none

package vsm_pkg;

   localparam int MAX_VECTOR_LEN = 64;
   localparam int ADDR_W         = $clog2(MAX_VECTOR_LEN);
   localparam int CNT_W          = ADDR_W + 1;
   localparam int DATA_W         = 16;
   localparam int CFG_W          = 7;
   localparam int EXP_W          = 17;              // Q1.16, 0..65536
   localparam int SUM_W          = EXP_W + ADDR_W;
   localparam int PROB_W         = 16;
   localparam int FRAC_W         = 33;              // Q0.32, 0..2^32
   localparam int STEP_W         = 4;
   localparam int EXP_CUTOFF     = 12;              // whole units where exp rounds to zero

   localparam logic [30:0] EXP_NEG_ONE = 31'd1580030169;  // exp(-1) in Q0.32

   typedef logic [255:0][FRAC_W-1:0] frac_table_type;

   // exp(-r/256) in Q0.32 by a 12-term Horner series, evaluated at elaboration
   function automatic frac_table_type build_frac_table();
      frac_table_type tab;
      logic [63:0]    e;
      logic [63:0]    p;
      logic [63:0]    q;
      for (int r = 0; r < 256; r++) begin
         e = 64'd1 << 32;
         for (int k = 12; k >= 1; k--) begin
            p = 64'(r) * e;
            case (k)
               12: q = p / 64'd3072;
               11: q = p / 64'd2816;
               10: q = p / 64'd2560;
               9:  q = p / 64'd2304;
               8:  q = p / 64'd2048;
               7:  q = p / 64'd1792;
               6:  q = p / 64'd1536;
               5:  q = p / 64'd1280;
               4:  q = p / 64'd1024;
               3:  q = p / 64'd768;
               2:  q = p / 64'd512;
               default: q = p / 64'd256;
            endcase
            e = (64'd1 << 32) - q;
         end
         tab[r] = e[FRAC_W-1:0];
      end
      return tab;
   endfunction

   localparam frac_table_type EXP_FRAC = build_frac_table();

endpackage

`default_nettype wire

>>> hdl/vsm_exp_unit.sv
// ----------------------------------------------------------------------------
// vsm_exp_unit
// exp(-t/256) as Q1.16: table lookup on the fraction, then one multiply
// by exp(-1) per cycle for each whole unit of t; zero at 12 whole units or more.
// ----------------------------------------------------------------------------
`default_nettype none

module vsm_exp_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [vsm_pkg::DATA_W-1:0] diff,
   output logic                            done,
   output logic [vsm_pkg::EXP_W-1:0]       value
);
   import vsm_pkg::*;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   steps_ff, steps_in;
   logic [FRAC_W-1:0]   e_ff, e_in;
   logic [EXP_W-1:0]    value_ff, value_in;
   logic [63:0]         prod;
   logic [63:0]         rounded;
   logic [FRAC_W:0]     scaled;

   assign prod    = 64'(e_ff) * 64'(EXP_NEG_ONE);
   assign rounded = prod + (64'd1 << 31);
   assign scaled  = {1'b0, e_ff} + (34'd1 << 15);

   // Load on start, scale down by exp(-1) per step, round out at the end
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      steps_in = steps_ff;
      e_in     = e_ff;
      value_in = value_ff;
      if (start) begin
         if (diff[15:8] >= 8'(EXP_CUTOFF)) begin
            done_in  = 1'b1;
            value_in = '0;
         end else begin
            busy_in  = 1'b1;
            steps_in = diff[STEP_W+7:8];
            e_in     = EXP_FRAC[diff[7:0]];
         end
      end else if (busy_ff) begin
         if (steps_ff != '0) begin
            steps_in = steps_ff - 1'b1;
            e_in     = FRAC_W'(rounded[63:32]);
         end else begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            value_in = scaled[16 +: EXP_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      steps_ff <= steps_in;
      e_ff     <= e_in;
      value_ff <= value_in;
   end

   assign done  = done_ff;
   assign value = value_ff;

endmodule

`default_nettype wire

>>> hdl/vsm_div_unit.sv
// ----------------------------------------------------------------------------
// vsm_div_unit
// Restoring divider, one quotient bit per cycle: (e*65536 + sum/2) / sum,
// saturated to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module vsm_div_unit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [vsm_pkg::EXP_W-1:0]  numer,
   input  wire logic [vsm_pkg::SUM_W-1:0]  total,
   output logic                            done,
   output logic [vsm_pkg::PROB_W-1:0]      quotient
);
   import vsm_pkg::*;

   localparam int NUM_W = EXP_W + 17;
   localparam int BIT_W = $clog2(EXP_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [BIT_W-1:0]   bits_ff, bits_in;
   logic [SUM_W-1:0]   rem_ff, rem_in;
   logic [EXP_W-1:0]   shift_ff, shift_in;
   logic [EXP_W-1:0]   quot_ff, quot_in;
   logic [NUM_W-1:0]   dividend;
   logic [SUM_W:0]     trial;
   logic [SUM_W:0]     diff;

   assign dividend = {numer, 16'd0, 1'b0} >> 1;
   assign trial    = {rem_ff, shift_ff[EXP_W-1]};
   assign diff     = trial - {1'b0, total};

   // Shift one numerator bit into the remainder per cycle
   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      bits_in  = bits_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         bits_in  = BIT_W'(EXP_W);
         rem_in   = SUM_W'((dividend + NUM_W'(total >> 1)) >> EXP_W);
         shift_in = EXP_W'(dividend + NUM_W'(total >> 1));
         quot_in  = '0;
      end else if (busy_ff) begin
         shift_in = {shift_ff[EXP_W-2:0], 1'b0};
         if (!diff[SUM_W]) begin
            rem_in  = diff[SUM_W-1:0];
            quot_in = {quot_ff[EXP_W-2:0], 1'b1};
         end else begin
            rem_in  = trial[SUM_W-1:0];
            quot_in = {quot_ff[EXP_W-2:0], 1'b0};
         end
         bits_in = bits_ff - 1'b1;
         if (bits_ff == BIT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bits_ff  <= bits_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff[EXP_W-1] ? '1 : quot_ff[PROB_W-1:0];

endmodule

`default_nettype wire

>>> hdl/vector_softmax_top.sv
// ----------------------------------------------------------------------------
// vector_softmax_top
// Max-stabilized softmax over vectors of up to 64 Q8.8 elements.
// ----------------------------------------------------------------------------
// Elements are taken one per cycle into an element memory while the maximum
// is tracked. On the element that completes a vector, input stops and each
// element is read back and run through the exponential unit into an exp
// memory while the sum builds up; then each exp value is read back and
// divided by the sum in the bit-serial divider, and one probability item
// leaves per division. The output register lets the next division run while
// a result waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_softmax_top (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [vsm_pkg::CFG_W-1:0]  csr_wr_data,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [vsm_pkg::DATA_W-1:0] req_element_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [vsm_pkg::PROB_W-1:0]      rsp_probability,
   output logic                            rsp_last_of_vector
);
   import vsm_pkg::*;

   typedef enum logic [7:0] {
      ST_LOAD      = 8'b0000_0001,
      ST_EXP_FETCH = 8'b0000_0010,
      ST_EXP_START = 8'b0000_0100,
      ST_EXP_RUN   = 8'b0000_1000,
      ST_DIV_FETCH = 8'b0001_0000,
      ST_DIV_START = 8'b0010_0000,
      ST_DIV_RUN   = 8'b0100_0000,
      ST_DIV_HOLD  = 8'b1000_0000
   } state_type;

   localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};

   state_type                 state_ff, state_in;
   logic [CFG_W-1:0]          len_cfg_ff, len_cfg_in;
   logic [CNT_W-1:0]          load_cnt_ff, load_cnt_in;
   logic [CNT_W-1:0]          total_ff, total_in;
   logic [CNT_W-1:0]          idx_ff, idx_in;
   logic signed [DATA_W-1:0]  max_ff, max_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic [PROB_W-1:0]         held_ff, held_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PROB_W-1:0]         rsp_prob_ff, rsp_prob_in;
   logic                      rsp_last_ff, rsp_last_in;

   logic [DATA_W-1:0]         elem_mem [MAX_VECTOR_LEN];
   logic [EXP_W-1:0]          exp_mem  [MAX_VECTOR_LEN];
   logic signed [DATA_W-1:0]  elem_rd_ff;
   logic [EXP_W-1:0]          exp_rd_ff;
   logic                      elem_we;
   logic                      exp_we;
   logic [ADDR_W-1:0]         elem_wr_addr;

   logic [CNT_W-1:0]          eff_len;
   logic [CNT_W-1:0]          cnt_next;
   logic [CNT_W-1:0]          idx_next;
   logic                      req_take;
   logic                      out_free;
   logic [DATA_W:0]           diff_wide;
   logic                      exp_start, exp_done;
   logic [EXP_W-1:0]          exp_value;
   logic                      div_start, div_done;
   logic [PROB_W-1:0]         div_quot;

   // Clamp the configured length into 1..MAX_VECTOR_LEN
   always_comb begin
      if (len_cfg_ff == '0) begin
         eff_len = CNT_W'(1);
      end else if (32'(len_cfg_ff) > MAX_VECTOR_LEN) begin
         eff_len = CNT_W'(MAX_VECTOR_LEN);
      end else begin
         eff_len = CNT_W'(len_cfg_ff);
      end
   end

   assign req_ready    = (state_ff == ST_LOAD);
   assign req_take     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cnt_next     = load_cnt_ff + 1'b1;
   assign idx_next     = idx_ff + 1'b1;
   assign elem_we      = req_take;
   assign elem_wr_addr = load_cnt_ff[ADDR_W-1:0];
   assign exp_we       = (state_ff == ST_EXP_RUN) && exp_done;
   assign exp_start    = (state_ff == ST_EXP_START);
   assign div_start    = (state_ff == ST_DIV_START);
   assign diff_wide    = {max_ff[DATA_W-1], max_ff} - {elem_rd_ff[DATA_W-1], elem_rd_ff};

   // Element memory: written while loading, read back for the exp pass
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_wr_addr] <= req_element_value;
      end
      elem_rd_ff <= elem_mem[idx_ff[ADDR_W-1:0]];
   end

   // Exp memory: written by the exp pass, read back for the divide pass
   always_ff @(posedge clock) begin
      if (exp_we) begin
         exp_mem[idx_ff[ADDR_W-1:0]] <= exp_value;
      end
      exp_rd_ff <= exp_mem[idx_ff[ADDR_W-1:0]];
   end

   vsm_exp_unit u_exp (
      .clock (clock),
      .reset (reset),
      .start (exp_start),
      .diff  (diff_wide[DATA_W-1:0]),
      .done  (exp_done),
      .value (exp_value)
   );

   vsm_div_unit u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (exp_rd_ff),
      .total    (sum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Sequence load, exp pass and divide pass
   always_comb begin
      state_in     = state_ff;
      len_cfg_in   = csr_wr_en ? csr_wr_data : len_cfg_ff;
      load_cnt_in  = load_cnt_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      max_in       = max_ff;
      sum_in       = sum_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_prob_in  = rsp_prob_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               load_cnt_in = cnt_next;
               if (req_element_value > max_ff) begin
                  max_in = req_element_value;
               end
               if (cnt_next >= eff_len) begin
                  total_in = cnt_next;
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = ST_EXP_FETCH;
               end
            end
         end
         ST_EXP_FETCH: state_in = ST_EXP_START;
         ST_EXP_START: state_in = ST_EXP_RUN;
         ST_EXP_RUN: begin
            if (exp_done) begin
               sum_in = sum_ff + SUM_W'(exp_value);
               if (idx_next == total_ff) begin
                  idx_in   = '0;
                  state_in = ST_DIV_FETCH;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_EXP_FETCH;
               end
            end
         end
         ST_DIV_FETCH: state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_RUN;
         ST_DIV_RUN: begin
            if (div_done) begin
               held_in  = div_quot;
               state_in = ST_DIV_HOLD;
            end
         end
         ST_DIV_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prob_in  = held_ff;
               rsp_last_in  = (idx_next == total_ff);
               if (idx_next == total_ff) begin
                  load_cnt_in = '0;
                  max_in      = MOST_NEG;
                  state_in    = ST_LOAD;
               end else begin
                  idx_in   = idx_next;
                  state_in = ST_DIV_FETCH;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         len_cfg_ff   <= CFG_W'(MAX_VECTOR_LEN);
         load_cnt_ff  <= '0;
         total_ff     <= '0;
         idx_ff       <= '0;
         max_ff       <= MOST_NEG;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_cfg_ff   <= len_cfg_in;
         load_cnt_ff  <= load_cnt_in;
         total_ff     <= total_in;
         idx_ff       <= idx_in;
         max_ff       <= max_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff     <= held_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_probability    = rsp_prob_ff;
   assign rsp_last_of_vector = rsp_last_ff;

endmodule

`default_nettype wire

>>> hdl/vsm_checker.sv
// ----------------------------------------------------------------------------
// vsm_checker
// Port-level checks on the softmax block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module vsm_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // Hold a result item until it is taken
   `VSM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // Drop input ready only right after the item that completes a vector
   `VSM_ASSERT(a_ready_drop, clock, reset, $fell(req_ready) |-> $past(req_valid && req_ready))

   // Emit a new result only out of the output pass
   `VSM_ASSERT(a_rsp_rise, clock, reset, $rose(rsp_valid) |-> $past(!req_ready))

   // Clear the result side on reset
   `VSM_ASSERT_ALWAYS(a_rsp_reset, clock, reset |=> !rsp_valid)

endmodule

bind vector_softmax_top vsm_checker u_vsm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

`default_nettype wire
